@@ sv/fsts_pkg.sv @@
`timescale 1ns / 1ps
// Package for the fair share tick scheduler: types, codes and weight table.
// No dependencies.
package fsts_pkg;

	localparam int VR_W = 48;
	localparam int WT_W = 17;
	localparam int WSUM_W = 25;
	localparam int SL_W = 26;
	localparam logic [VR_W-1:0] VR_MAX = {VR_W{1'b1}};

	localparam logic [1:0] ST_ADMIT = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RAN = 2'd2;
	localparam logic [1:0] ST_IDLE = 2'd3;

	localparam logic [1:0] REG_LATENCY = 2'd0;
	localparam logic [1:0] REG_MIN_SLICE = 2'd1;
	localparam logic [1:0] REG_REF_WEIGHT = 2'd2;

	localparam logic [3:0] PRIO_MAX = 4'd9;

	function automatic logic [WT_W-1:0] prio_weight(input logic [3:0] p);
		logic [WT_W-1:0] w;
		case (p)
			4'd0: w = 17'd88761;
			4'd1: w = 17'd29154;
			4'd2: w = 17'd9548;
			4'd3: w = 17'd3121;
			4'd4: w = 17'd1024;
			4'd5: w = 17'd335;
			4'd6: w = 17'd110;
			4'd7: w = 17'd35;
			4'd8: w = 17'd10;
			default: w = 17'd2;
		endcase
		return w;
	endfunction

	typedef struct packed {
		logic scan_clr;
		logic scan_step;
		logic excl_run;
		logic div_start;
		logic div_slice;
		logic do_admit;
		logic do_select;
		logic do_run;
		logic do_finish;
		logic do_idle;
		logic do_full;
	} fsts_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_done;
		logic running;
		logic table_full;
	} fsts_sts_t;

endpackage

@@ sv/fsts_divider.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing.
module fsts_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] trial;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// one-cycle pulse once the last quotient bit is in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
	end
	assign done = done_q;
	assign quot = quot_q;
endmodule

@@ sv/fsts_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the tick scheduler.
// Depends on fsts_pkg.
module fsts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_go,
	input  logic               in_mode,
	input  logic               out_free,
	input  fsts_pkg::fsts_sts_t sts,
	output fsts_pkg::fsts_cmd_t cmd,
	output logic               busy
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_ASCAN = 10'b0000000010,
		S_ADMIT = 10'b0000000100,
		S_TSCAN = 10'b0000001000,
		S_SLDIV = 10'b0000010000,
		S_VDIV = 10'b0000100000,
		S_RUN = 10'b0001000000,
		S_ESCAN = 10'b0010000000,
		S_FIN = 10'b0100000000,
		S_WAIT = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					cmd.scan_clr = 1'b1;
					sel_d = 1'b0;
					if (!in_mode) state_d = S_ASCAN;
					else if (sts.running) begin
						cmd.div_start = 1'b1;
						state_d = S_VDIV;
					end else state_d = S_TSCAN;
				end
			end
			S_ASCAN: begin
				cmd.scan_step = 1'b1;
				cmd.excl_run = 1'b1;
				if (sts.scan_last) state_d = S_ADMIT;
			end
			S_ADMIT: begin
				if (sts.table_full) cmd.do_full = 1'b1;
				else cmd.do_admit = 1'b1;
				state_d = S_WAIT;
			end
			S_TSCAN: begin
				cmd.scan_step = 1'b1;
				cmd.excl_run = 1'b1;
				if (sts.scan_last) begin
					cmd.do_select = 1'b1;
					state_d = S_SLDIV;
				end
			end
			S_SLDIV: begin
				if (!sts.running) begin
					cmd.do_idle = 1'b1;
					state_d = S_WAIT;
				end else if (!sel_q) begin
					cmd.div_start = 1'b1;
					cmd.div_slice = 1'b1;
					sel_d = 1'b1;
				end else if (sts.div_done) begin
					cmd.div_slice = 1'b1;
					cmd.div_start = 1'b1;
					state_d = S_VDIV;
				end else cmd.div_slice = 1'b1;
			end
			S_VDIV: begin
				if (sts.div_done) state_d = S_RUN;
			end
			S_RUN: begin
				cmd.do_run = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_ESCAN;
			end
			S_ESCAN: begin
				cmd.scan_step = 1'b1;
				cmd.excl_run = 1'b1;
				if (sts.scan_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.do_finish = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_go |-> state_q == S_IDLE) else $error("item taken while busy");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_admit, cmd.do_full, cmd.do_idle, cmd.do_finish}))
		else $error("conflicting result commands");
endmodule

@@ sv/fsts_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the tick scheduler: slot table, min scan, shared divider, results.
// Depends on fsts_pkg and fsts_divider.
module fsts_datapath #(
	parameter int MAX_TASKS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_go,
	input  logic [7:0]         in_id,
	input  logic [3:0]         in_prio,
	input  logic [15:0]        in_burst,
	input  logic [15:0]        latency,
	input  logic [15:0]        min_slice,
	input  logic [15:0]        ref_wt,
	input  fsts_pkg::fsts_cmd_t cmd,
	output fsts_pkg::fsts_sts_t sts,
	output logic               res_load,
	output logic [1:0]         res_status,
	output logic [7:0]         res_id,
	output logic               res_first,
	output logic               res_done,
	output logic               res_pre,
	output logic [31:0]        res_time,
	output logic [47:0]        res_vr
);
	localparam int IX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int VR_W = fsts_pkg::VR_W;
	localparam int WT_W = fsts_pkg::WT_W;
	localparam int WS_W = fsts_pkg::WSUM_W;
	localparam int SL_W = fsts_pkg::SL_W;

	logic [MAX_TASKS-1:0] valid_q;
	logic [7:0] ident_q [MAX_TASKS];
	logic [WT_W-1:0] weight_q [MAX_TASKS];
	logic [15:0] remain_q [MAX_TASKS];
	logic [VR_W-1:0] vr_q [MAX_TASKS];
	logic started_q [MAX_TASKS];

	logic [7:0] id_q;
	logic [3:0] prio_q;
	logic [15:0] burst_q;
	logic [IX_W-1:0] run_slot_q;
	logic run_valid_q;
	logic [SL_W-1:0] slice_q;
	logic [WS_W-1:0] wsum_q;
	logic [31:0] time_q;

	logic [IX_W:0] scan_q;
	logic best_ok_q;
	logic [IX_W-1:0] best_q;
	logic [VR_W-1:0] best_vr_q;
	logic [7:0] best_id_q;
	logic [IX_W-1:0] sidx;
	logic cand, better;

	assign sidx = scan_q[IX_W-1:0];
	assign cand = valid_q[sidx] && !(cmd.excl_run && run_valid_q && sidx == run_slot_q);
	assign better = !best_ok_q || vr_q[sidx] < best_vr_q ||
		(vr_q[sidx] == best_vr_q && ident_q[sidx] < best_id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			best_ok_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_q <= '0;
			best_ok_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (cand && better) best_ok_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.scan_step && cand && better) begin
			best_q <= sidx;
			best_vr_q <= vr_q[sidx];
			best_id_q <= ident_q[sidx];
		end
	end
	assign sts.scan_last = cmd.scan_step && (scan_q == (IX_W+1)'(MAX_TASKS - 1));

	logic full;
	logic [IX_W-1:0] free_ix;
	always_comb begin
		full = 1'b1;
		free_ix = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				full = 1'b0;
				free_ix = IX_W'(i);
			end
		end
	end
	assign sts.table_full = full;
	assign sts.running = run_valid_q;

	// shared divider: slice numerator or vruntime delta
	logic div_done;
	logic [47:0] div_quot;
	logic [47:0] numer;
	logic [WS_W-1:0] denom;
	logic [IX_W-1:0] rs;
	logic [WT_W-1:0] rw;
	logic [32:0] sl_prod;
	assign rs = run_slot_q;
	assign rw = weight_q[rs];
	assign sl_prod = 33'(latency) * 33'(rw);
	always_comb begin
		if (cmd.div_slice && !div_done) begin
			numer = {7'd0, sl_prod, 8'd0};
			denom = (wsum_q == '0) ? WS_W'(1) : wsum_q;
		end else begin
			numer = {16'd0, ref_wt, 16'd0};
			denom = (rw == '0) ? WS_W'(1) : WS_W'(rw);
		end
	end

	fsts_divider #(.NUM_W(48), .DEN_W(WS_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.numer(numer), .denom(denom), .done(div_done), .quot(div_quot));

	assign sts.div_done = div_done;

	logic [SL_W-1:0] floor_sl, lat_sl;
	assign floor_sl = SL_W'({min_slice, 8'd0});
	assign lat_sl = SL_W'({latency, 8'd0});

	logic [VR_W:0] vsum;
	logic [VR_W-1:0] new_vr;
	assign vsum = {1'b0, vr_q[rs]} + {1'b0, div_quot};
	assign new_vr = vsum[VR_W] ? fsts_pkg::VR_MAX : vsum[VR_W-1:0];

	logic [WT_W-1:0] aw;
	assign aw = fsts_pkg::prio_weight((prio_q > fsts_pkg::PRIO_MAX) ? fsts_pkg::PRIO_MAX
		: prio_q);

	always_ff @(posedge clk) begin
		if (in_go) begin
			id_q <= in_id;
			prio_q <= in_prio;
			burst_q <= in_burst;
		end
		if (cmd.do_admit) begin
			ident_q[free_ix] <= id_q;
			weight_q[free_ix] <= aw;
			remain_q[free_ix] <= (burst_q == '0) ? 16'd1 : burst_q;
			vr_q[free_ix] <= best_ok_q ? best_vr_q : (run_valid_q ? vr_q[rs] : '0);
			started_q[free_ix] <= 1'b0;
		end
		if (cmd.do_run) begin
			started_q[rs] <= 1'b1;
			remain_q[rs] <= remain_q[rs] - 1'b1;
			vr_q[rs] <= new_vr;
		end
	end

	logic first_q, expired_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			run_slot_q <= '0;
			run_valid_q <= 1'b0;
			slice_q <= '0;
			wsum_q <= '0;
			time_q <= '0;
			first_q <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			if (cmd.do_admit) begin
				valid_q[free_ix] <= 1'b1;
				wsum_q <= wsum_q + WS_W'(aw);
			end
			if (cmd.do_select && (best_ok_q || (cand && better))) begin
				run_valid_q <= 1'b1;
				run_slot_q <= (cand && better) ? sidx : best_q;
			end
			if (cmd.div_slice && cmd.div_start && div_done)
				slice_q <= (SL_W'(div_quot) < floor_sl || div_quot[47:SL_W] != '0)
					? ((div_quot[47:SL_W] != '0) ? SL_W'(div_quot) : floor_sl)
					: SL_W'(div_quot);
			if (cmd.do_idle) time_q <= time_q + 1'b1;
			if (cmd.do_run) begin
				time_q <= time_q + 1'b1;
				first_q <= !started_q[rs];
				expired_q <= slice_q <= SL_W'(256);
				slice_q <= (slice_q <= SL_W'(256)) ? '0 : slice_q - SL_W'(256);
			end
			if (cmd.do_finish) begin
				if (remain_q[rs] == '0) begin
					valid_q[rs] <= 1'b0;
					wsum_q <= wsum_q - WS_W'(rw);
					run_valid_q <= 1'b0;
					slice_q <= '0;
				end else if (expired_q) begin
					if (best_ok_q && best_vr_q < vr_q[rs]) run_valid_q <= 1'b0;
					else if (best_ok_q) slice_q <= floor_sl;
					else slice_q <= lat_sl;
				end
			end
		end
	end

	always_comb begin
		res_load = cmd.do_admit || cmd.do_full || cmd.do_idle || cmd.do_finish;
		res_status = fsts_pkg::ST_IDLE;
		res_id = '0;
		res_first = 1'b0;
		res_done = 1'b0;
		res_pre = 1'b0;
		res_time = time_q;
		res_vr = '0;
		if (cmd.do_admit) begin
			res_status = fsts_pkg::ST_ADMIT;
			res_id = id_q;
			res_vr = best_ok_q ? best_vr_q : (run_valid_q ? vr_q[rs] : '0);
		end else if (cmd.do_full) begin
			res_status = fsts_pkg::ST_FULL;
			res_id = id_q;
		end else if (cmd.do_idle) begin
			res_time = time_q + 1'b1;
		end else if (cmd.do_finish) begin
			res_status = fsts_pkg::ST_RAN;
			res_id = ident_q[rs];
			res_first = first_q;
			res_done = (remain_q[rs] == '0);
			res_pre = (remain_q[rs] != '0) && expired_q && best_ok_q &&
				(best_vr_q < vr_q[rs]);
			res_vr = vr_q[rs];
		end
	end

	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_admit |=> wsum_q != '0) else $error("weight sum lost");
	a_run_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_run |-> run_valid_q && valid_q[rs]) else $error("running empty slot");
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_full |=> $stable(time_q)) else $error("time moved on reject");
endmodule

@@ sv/fair_share_tick_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Fair share tick scheduler. Depends on fsts_pkg, fsts_ctrl, fsts_datapath.
// Admit: a slot scan, then the result. Tick: when a task runs on, a vruntime division,
// the run and a slot scan; when one is picked, a slot scan and the slice and vruntime
// divisions first; when idle, a slot scan only; all on one shared 48-step restoring divider.
// One item at a time; a result waits in an output register, and the next input
// beat is taken in the cycle after the result beat at the earliest.
// Reset clears all control state and the slot valid bits; no clearing pass.
module fair_share_tick_scheduler_unit #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  task_id,
	input  logic [3:0]  priority_req,
	input  logic [15:0] burst,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  run_id,
	output logic        first_run,
	output logic        completed,
	output logic        preempted,
	output logic [31:0] tick_time,
	output logic [47:0] run_vruntime,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] latency_q, min_slice_q, ref_wt_q;
	fsts_pkg::fsts_cmd_t cmd;
	fsts_pkg::fsts_sts_t sts;
	logic busy, in_go, res_load;
	logic [1:0] r_status;
	logic [7:0] r_id;
	logic r_first, r_done, r_pre;
	logic [31:0] r_time;
	logic [47:0] r_vr;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q <= 16'd20;
			min_slice_q <= 16'd4;
			ref_wt_q <= 16'd1024;
		end else if (cfg_valid) begin
			case (cfg_index)
				fsts_pkg::REG_LATENCY: latency_q <= cfg_data;
				fsts_pkg::REG_MIN_SLICE: min_slice_q <= cfg_data;
				fsts_pkg::REG_REF_WEIGHT: ref_wt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !busy;
	assign in_go = in_valid && in_ready;

	fsts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .in_mode(mode),
		.out_free(!out_valid || out_ready), .sts(sts), .cmd(cmd), .busy(busy));

	fsts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .in_id(task_id),
		.in_prio(priority_req), .in_burst(burst), .latency(latency_q),
		.min_slice(min_slice_q), .ref_wt(ref_wt_q), .cmd(cmd), .sts(sts),
		.res_load(res_load), .res_status(r_status), .res_id(r_id),
		.res_first(r_first), .res_done(r_done), .res_pre(r_pre),
		.res_time(r_time), .res_vr(r_vr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			status <= r_status;
			run_id <= r_id;
			first_run <= r_first;
			completed <= r_done;
			preempted <= r_pre;
			tick_time <= r_time;
			run_vruntime <= r_vr;
		end
	end
endmodule
